// File: hw/rtl/rgbled_pkg.sv
// shared types and constants for the rgb led strip serial driver
package rgbled_pkg;

   localparam int unsigned MaxLeds   = 64;
   localparam int unsigned AddrWidth = $clog2(MaxLeds);
   localparam int unsigned LenWidth  = 7;
   localparam int unsigned BitsPerLed = 24;

   // operation codes of an input word
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_START = 2'd3
   } op_type;

   // waveform phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_HIGH  = 2'd1,
      PH_LOW   = 2'd2,
      PH_LATCH = 2'd3
   } phase_type;

   // register indexes
   localparam logic [2:0] CSR_ZERO_HIGH    = 3'd0;
   localparam logic [2:0] CSR_ZERO_LOW     = 3'd1;
   localparam logic [2:0] CSR_ONE_HIGH     = 3'd2;
   localparam logic [2:0] CSR_ONE_LOW      = 3'd3;
   localparam logic [2:0] CSR_LATCH        = 3'd4;
   localparam logic [2:0] CSR_STRIP_LENGTH = 3'd5;

   // register reset values
   localparam logic [7:0]  ZERO_HIGH_RST    = 8'd5;
   localparam logic [7:0]  ZERO_LOW_RST     = 8'd18;
   localparam logic [7:0]  ONE_HIGH_RST     = 8'd16;
   localparam logic [7:0]  ONE_LOW_RST      = 8'd9;
   localparam logic [15:0] LATCH_RST        = 16'd20000;
   localparam logic [6:0]  STRIP_LENGTH_RST = 7'd60;

endpackage

// File: hw/rtl/rgb_led_strip_serial_driver_core.sv
// serial encoder for a one-wire rgb led strip with pixel store and output register
// each input word's result is registered and presented in the cycle after acceptance
// throughput: one input word per cycle unless the result stalls; one result per word
// pixel reads use a registered memory port, set at frame start and at each led change
// reset (synchronous, active high) restores the timing registers, goes idle and marks
// every pixel as zero through per-entry valid bits, with no clearing pass
module rgb_led_strip_serial_driver_core (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // input word channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_pixel_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   // result word channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_data_line,
   output logic        rsp_busy_res,
   output logic        rsp_rejected,
   output logic        rsp_frame_done
);

   localparam int unsigned AW = rgbled_pkg::AddrWidth;
   localparam int unsigned LW = rgbled_pkg::LenWidth;
   localparam int unsigned BW = rgbled_pkg::BitsPerLed;

   // timing registers
   logic [7:0]  zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [15:0] latch_ff;
   logic [6:0]  strip_len_ff;

   // pixel store, valid bits and registered read port
   logic [BW-1:0]      pixel_mem [rgbled_pkg::MaxLeds];
   logic [rgbled_pkg::MaxLeds-1:0] pix_valid_ff;
   logic [BW-1:0]      rd_data_ff;
   logic               rd_valid_ff;

   // waveform state
   rgbled_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0] led_ff, led_in;
   logic [4:0]    bit_ff, bit_in;
   logic [BW-1:0] shift_ff, shift_in;
   logic [15:0]   tick_ff, tick_in;
   logic          pending_ff, pending_in;

   // output register
   logic rsp_valid_ff;
   logic line_ff, busy_ff, rej_ff, done_ff;
   logic line_in, busy_in, rej_in, done_in;

   // memory controls
   logic          rd_en, wr_en, clr_en;
   logic [AW-1:0] rd_addr;

   logic          req_fire;
   logic [LW-1:0] eff_len;
   logic [BW-1:0] cur_word;
   logic          bit_one;
   logic [7:0]    hi_thr, lo_thr, hi_lim, lo_lim;
   logic [15:0]   latch_lim, tick_inc;
   logic [4:0]    bit_inc;
   logic [LW-1:0] led_inc;
   logic          hi_end, lo_end, latch_end, word_end, strip_end;

   // output stage frees up when empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= rgbled_pkg::ZERO_HIGH_RST;
         zero_low_ff  <= rgbled_pkg::ZERO_LOW_RST;
         one_high_ff  <= rgbled_pkg::ONE_HIGH_RST;
         one_low_ff   <= rgbled_pkg::ONE_LOW_RST;
         latch_ff     <= rgbled_pkg::LATCH_RST;
         strip_len_ff <= rgbled_pkg::STRIP_LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rgbled_pkg::CSR_ZERO_HIGH:    zero_high_ff <= csr_wdata[7:0];
            rgbled_pkg::CSR_ZERO_LOW:     zero_low_ff  <= csr_wdata[7:0];
            rgbled_pkg::CSR_ONE_HIGH:     one_high_ff  <= csr_wdata[7:0];
            rgbled_pkg::CSR_ONE_LOW:      one_low_ff   <= csr_wdata[7:0];
            rgbled_pkg::CSR_LATCH:        latch_ff     <= csr_wdata;
            rgbled_pkg::CSR_STRIP_LENGTH: strip_len_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // strip length saturates at the store depth
   assign eff_len = (strip_len_ff > LW'(rgbled_pkg::MaxLeds)) ?
                    LW'(rgbled_pkg::MaxLeds) : strip_len_ff;

   // ------------------------------------------------------- shared datapath
   // right after an led load the word still sits in the memory read register;
   // an entry never written since reset or clear reads as black
   assign cur_word = pending_ff ? (rd_valid_ff ? rd_data_ff : '0) : shift_ff;
   assign bit_one  = cur_word[BW-1];

   assign hi_thr    = bit_one ? one_high_ff : zero_high_ff;
   assign lo_thr    = bit_one ? one_low_ff  : zero_low_ff;
   // a zero duration behaves as one tick
   assign hi_lim    = (hi_thr == 8'd0) ? 8'd1 : hi_thr;
   assign lo_lim    = (lo_thr == 8'd0) ? 8'd1 : lo_thr;
   assign latch_lim = (latch_ff == 16'd0) ? 16'd1 : latch_ff;

   assign tick_inc  = tick_ff + 16'd1;
   assign bit_inc   = bit_ff + 5'd1;
   assign led_inc   = led_ff + LW'(1);

   assign hi_end    = tick_inc >= {8'd0, hi_lim};
   assign lo_end    = tick_inc >= {8'd0, lo_lim};
   assign latch_end = tick_inc >= latch_lim;
   assign word_end  = bit_inc >= 5'(BW);
   assign strip_end = led_inc >= eff_len;

   // ------------------------------------------------------------ next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         rgbled_pkg::PH_IDLE: begin
            if (req_operation == rgbled_pkg::OP_START) begin
               phase_in = (eff_len == '0) ? rgbled_pkg::PH_LATCH : rgbled_pkg::PH_HIGH;
            end
         end
         rgbled_pkg::PH_HIGH: begin
            if (hi_end) begin
               phase_in = rgbled_pkg::PH_LOW;
            end
         end
         rgbled_pkg::PH_LOW: begin
            if (lo_end) begin
               phase_in = (word_end && strip_end) ? rgbled_pkg::PH_LATCH :
                          rgbled_pkg::PH_HIGH;
            end
         end
         rgbled_pkg::PH_LATCH: begin
            if (latch_end) begin
               phase_in = rgbled_pkg::PH_IDLE;
            end
         end
         default: phase_in = rgbled_pkg::PH_IDLE;
      endcase
   end

   // ------------------------------------------------- counters and outputs
   always_comb begin
      led_in     = led_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      pending_in = pending_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      clr_en     = 1'b0;
      line_in    = 1'b0;
      busy_in    = 1'b0;
      rej_in     = 1'b0;
      done_in    = 1'b0;

      if (phase_ff != rgbled_pkg::PH_IDLE) begin
         // busy: every word advances the waveform one slot
         busy_in    = 1'b1;
         rej_in     = req_operation != rgbled_pkg::OP_TICK;
         shift_in   = cur_word;
         pending_in = 1'b0;
         unique case (phase_ff)
            rgbled_pkg::PH_HIGH: begin
               line_in = 1'b1;
               tick_in = hi_end ? 16'd0 : tick_inc;
            end
            rgbled_pkg::PH_LOW: begin
               tick_in = lo_end ? 16'd0 : tick_inc;
               if (lo_end) begin
                  shift_in = {cur_word[BW-2:0], 1'b0};
                  bit_in   = bit_inc;
                  if (word_end) begin
                     led_in = led_inc;
                     bit_in = 5'd0;
                     if (!strip_end) begin
                        // fetch the next led, its word shows up next cycle
                        pending_in = 1'b1;
                        rd_en      = req_fire;
                        rd_addr    = led_inc[AW-1:0];
                     end
                  end
               end
            end
            rgbled_pkg::PH_LATCH: begin
               tick_in = latch_end ? 16'd0 : tick_inc;
               done_in = latch_end;
            end
            default: ;
         endcase
      end else begin
         case (req_operation)
            rgbled_pkg::OP_WRITE: begin
               // indexes past the strip are dropped silently
               wr_en = req_fire && ({1'b0, req_pixel_index} < eff_len);
            end
            rgbled_pkg::OP_CLEAR: begin
               clr_en = req_fire;
            end
            rgbled_pkg::OP_START: begin
               busy_in = 1'b1;
               led_in  = '0;
               bit_in  = 5'd0;
               tick_in = 16'd0;
               if (eff_len == '0) begin
                  shift_in   = '0;
                  pending_in = 1'b0;
               end else begin
                  pending_in = 1'b1;
                  rd_en      = req_fire;
                  rd_addr    = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rgbled_pkg::PH_IDLE;
         led_ff     <= '0;
         bit_ff     <= 5'd0;
         shift_ff   <= '0;
         tick_ff    <= 16'd0;
         pending_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         led_ff     <= led_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         tick_ff    <= tick_in;
         pending_ff <= pending_in;
      end
   end

   // ---------------------------------------------------------- pixel store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem[req_pixel_index] <= {req_green, req_red, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= pixel_mem[rd_addr];
         rd_valid_ff <= pix_valid_ff[rd_addr];
      end
   end

   // clear all pixels just drops every valid bit
   always_ff @(posedge clock) begin
      if (reset || clr_en) begin
         pix_valid_ff <= '0;
      end else if (wr_en) begin
         pix_valid_ff[req_pixel_index] <= 1'b1;
      end
   end

   // -------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_ff <= line_in;
         busy_ff <= busy_in;
         rej_ff  <= rej_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_line  = line_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_rejected   = rej_ff;
   assign rsp_frame_done = done_ff;

`ifndef ASSERT_OFF
   // a word waiting in the memory read register only exists inside a frame
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == rgbled_pkg::PH_IDLE |-> !pending_ff)
      else $error("pixel load pending while idle");

   // bit counter never reaches the word length
   assert property (@(posedge clock) disable iff (reset)
      bit_ff < 5'(BW))
      else $error("bit position out of range");

   // a finished frame returns to idle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && done_in |=> phase_ff == rgbled_pkg::PH_IDLE)
      else $error("frame done without returning to idle");

   // line high, rejection and frame end all belong to a busy slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (line_ff || rej_ff || done_ff) |-> busy_ff)
      else $error("busy-only result flag seen on idle slot");
`endif

endmodule
